// ===== rtl/sample_mean_stddev_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sample mean and deviation engine
// Concurrent checks that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_MEAN_STDDEV_ENGINE_ASSERT_SVH
`define SAMPLE_MEAN_STDDEV_ENGINE_ASSERT_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define SMSE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("smse assertion failed");
// Condition that must never be true outside reset.
`define SMSE_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("smse forbidden condition seen");
`else
`define SMSE_ASSERT(lbl, clk, rst, prop)
`define SMSE_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ===== rtl/smse_pkg.sv =====
// ----------------------------------------------------------------------------
// Sample mean and deviation engine package
// Item types and fixed widths shared by the engine and its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package smse_pkg;

   // Width of the sample count register.
   localparam int CNT_W = 11;
   // Reset value of the sample count register.
   localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

   // One input item.
   typedef struct packed {
      logic signed [31:0] sample_value;
      logic               last_sample;
   } req_type;

   // One result item.
   typedef struct packed {
      logic signed [31:0] mean_value;
      logic        [31:0] std_deviation;
      logic        [31:0] margin_of_error;
      logic signed [31:0] smallest_sample;
      logic signed [31:0] largest_sample;
      logic               saturated;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/sample_mean_stddev_engine.sv =====
// ----------------------------------------------------------------------------
// Sample mean and standard deviation engine
// Collects signed Q16.16 samples and, after the last one, reports the mean,
// population standard deviation, margin of error, minimum and maximum.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  smse_pkg::req_type
//   rsp_     out        rsp_valid/rsp_stall  smse_pkg::rsp_type
//   csr_     in         csr_valid/csr_ready  sample count, 11 bits
//
// A sample is taken every cycle while the engine collects.
// After the last sample the engine stalls its input while the bit-serial
// divider, the shift-add squarer of the second pass and the square roots
// run, and until the output register can take the result.
// A finished result waits in the output register while the next set loads.
// Reset is synchronous and needs no clearing pass of the sample store.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sample_mean_stddev_engine_assert.svh"

module sample_mean_stddev_engine #(
   parameter int MAX_SAMPLES = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire smse_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output smse_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [smse_pkg::CNT_W-1:0]    csr_wdata
);

   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int FW    = AW + 1;
   localparam int SUM_W = 32 + AW;
   localparam int DVW   = 64 + AW;
   localparam int CW    = smse_pkg::CNT_W;

   typedef enum logic [3:0] {
      S_COLLECT,
      S_MEAN_GO,
      S_MEAN_WAIT,
      S_PASS_RD,
      S_PASS_LOAD,
      S_PASS_MUL,
      S_VAR_GO,
      S_VAR_WAIT,
      S_MOE_GO,
      S_MOE_WAIT,
      S_ROOT_V,
      S_ROOT_M,
      S_FINISH
   } state_type;

   state_type               state_ff;
   logic [CW-1:0]           count_cfg_ff;
   logic [FW-1:0]           fill_count_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [31:0]      min_ff;
   logic signed [31:0]      max_ff;
   logic                    overflow_ff;
   logic                    sat_ff;
   logic signed [31:0]      mean_ff;
   logic [FW-1:0]           idx_ff;
   logic [DVW-1:0]          acc_ff;
   logic [DVW-1:0]          mcand_ff;
   logic [31:0]             mplier_ff;
   logic [63:0]             mvar_ff;
   logic                    mvar_sat_ff;
   logic [63:0]             op_ff;
   logic [32:0]             rem_ff;
   logic [31:0]             root_ff;
   logic [5:0]              step_ff;
   logic [31:0]             stdv_ff;
   logic                    rsp_valid_ff;
   smse_pkg::rsp_type       rsp_ff;

   logic                    take;
   logic [CW-1:0]           n_eff;
   logic [SUM_W-1:0]        mag;
   logic [SUM_W-1:0]        mean_num;
   logic                    div_start;
   logic [DVW-1:0]          div_dividend;
   logic                    div_done;
   logic [DVW-1:0]          div_quot;
   logic                    mean_clip;
   logic signed [31:0]      mean_in;
   logic [31:0]             rd_data;
   logic signed [32:0]      diff;
   logic [31:0]             diff_mag;
   logic [34:0]             rem_sh;
   logic [34:0]             trial;
   logic                    root_fits;
   logic [31:0]             root_in;
   logic [32:0]             rem_in;
   logic                    out_free;

   assign take      = req_valid && !req_stall;
   assign req_stall = (state_ff != S_COLLECT);
   assign csr_ready = 1'b1;
   assign n_eff     = (count_cfg_ff == '0) ? CW'(1) : count_cfg_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Rounded mean: magnitude of the sum plus half the count.
   always_comb begin
      mag      = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      mean_num = mag + SUM_W'(n_eff >> 1);
   end

   // Clip the mean quotient to the signed 32-bit range.
   always_comb begin
      if (sum_ff[SUM_W-1]) begin
         mean_clip = (div_quot > DVW'(33'h0_8000_0000));
         mean_in   = mean_clip ? 32'sh8000_0000 : $signed(32'(32'd0 - div_quot[31:0]));
      end else begin
         mean_clip = (div_quot > DVW'(32'h7FFF_FFFF));
         mean_in   = mean_clip ? 32'sh7FFF_FFFF : $signed(div_quot[31:0]);
      end
   end

   // Divider operand selection.
   always_comb begin
      div_start = (state_ff == S_MEAN_GO) || (state_ff == S_VAR_GO) ||
                  (state_ff == S_MOE_GO);
      case (state_ff)
         S_MEAN_GO: div_dividend = DVW'(mean_num);
         S_VAR_GO:  div_dividend = acc_ff;
         default:   div_dividend = div_quot;
      endcase
   end

   // Deviation of the stored sample from the mean.
   always_comb begin
      diff     = {rd_data[31], rd_data} - {mean_ff[31], mean_ff};
      diff_mag = diff[32] ? 32'(33'(-diff)) : diff[31:0];
   end

   // One digit step of the square root, two radicand bits per cycle.
   always_comb begin
      rem_sh    = {rem_ff, op_ff[63:62]};
      trial     = {1'b0, root_ff, 2'b01};
      root_fits = (rem_sh >= trial);
      root_in   = {root_ff[30:0], root_fits};
      rem_in    = root_fits ? 33'(rem_sh - trial) : rem_sh[32:0];
   end

   smse_ram #(
      .WIDTH (32),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (take && (fill_count_ff < FW'(MAX_SAMPLES))),
      .wr_addr (fill_count_ff[AW-1:0]),
      .wr_data (req_data.sample_value),
      .rd_en   (state_ff == S_PASS_RD),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   smse_div #(
      .DW (DVW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (n_eff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Sequencer: collect, mean, second pass, two divides, two roots, result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_COLLECT;
         count_cfg_ff  <= smse_pkg::CNT_RESET;
         fill_count_ff <= '0;
         sum_ff        <= '0;
         min_ff        <= 32'sh7FFF_FFFF;
         max_ff        <= 32'sh8000_0000;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            count_cfg_ff <= csr_wdata;
         end
         // The output register fills from the final state and empties on accept.
         if ((state_ff == S_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_COLLECT: begin
               if (take) begin
                  if (fill_count_ff < FW'(MAX_SAMPLES)) begin
                     fill_count_ff <= fill_count_ff + 1'b1;
                     sum_ff        <= sum_ff + SUM_W'(req_data.sample_value);
                     if (req_data.sample_value < min_ff) begin
                        min_ff <= req_data.sample_value;
                     end
                     if (req_data.sample_value > max_ff) begin
                        max_ff <= req_data.sample_value;
                     end
                  end else begin
                     overflow_ff <= 1'b1;
                  end
                  if (req_data.last_sample) begin
                     state_ff <= S_MEAN_GO;
                  end
               end
            end
            S_MEAN_GO: begin
               state_ff <= S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
               if (div_done) begin
                  mean_ff  <= mean_in;
                  sat_ff   <= overflow_ff || mean_clip;
                  idx_ff   <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_PASS_RD;
               end
            end
            S_PASS_RD: begin
               state_ff <= (idx_ff == fill_count_ff) ? S_VAR_GO : S_PASS_LOAD;
            end
            S_PASS_LOAD: begin
               mcand_ff  <= DVW'(diff_mag);
               mplier_ff <= diff_mag;
               idx_ff    <= idx_ff + 1'b1;
               state_ff  <= S_PASS_MUL;
            end
            S_PASS_MUL: begin
               // Shift-add square, one multiplier bit per cycle.
               if (mplier_ff == '0) begin
                  state_ff <= S_PASS_RD;
               end else begin
                  if (mplier_ff[0]) begin
                     acc_ff <= acc_ff + mcand_ff;
                  end
                  mcand_ff  <= {mcand_ff[DVW-2:0], 1'b0};
                  mplier_ff <= {1'b0, mplier_ff[31:1]};
               end
            end
            S_VAR_GO: begin
               state_ff <= S_VAR_WAIT;
            end
            S_VAR_WAIT: begin
               if (div_done) begin
                  op_ff       <= div_quot[63:0];
                  mvar_sat_ff <= (div_quot[DVW-1:64] != '0);
                  state_ff    <= S_MOE_GO;
               end
            end
            S_MOE_GO: begin
               state_ff <= S_MOE_WAIT;
            end
            S_MOE_WAIT: begin
               if (div_done) begin
                  // A clipped margin quotient roots to all ones.
                  mvar_ff  <= (div_quot[DVW-1:64] != '0) ? {64{1'b1}} : div_quot[63:0];
                  sat_ff   <= sat_ff || mvar_sat_ff || (div_quot[DVW-1:64] != '0);
                  // The variance root starts; the margin waits its turn.
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  step_ff  <= 6'd32;
                  state_ff <= S_ROOT_V;
               end
            end
            S_ROOT_V: begin
               if (step_ff == 6'd1) begin
                  stdv_ff  <= mvar_sat_ff ? {32{1'b1}} : root_in;
                  op_ff    <= mvar_ff;
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  step_ff  <= 6'd32;
                  state_ff <= S_ROOT_M;
               end else begin
                  op_ff   <= {op_ff[61:0], 2'b00};
                  rem_ff  <= rem_in;
                  root_ff <= root_in;
                  step_ff <= step_ff - 1'b1;
               end
            end
            S_ROOT_M: begin
               op_ff   <= {op_ff[61:0], 2'b00};
               rem_ff  <= rem_in;
               root_ff <= root_in;
               step_ff <= step_ff - 1'b1;
               if (step_ff == 6'd1) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_ff.mean_value      <= mean_ff;
                  rsp_ff.std_deviation   <= stdv_ff;
                  rsp_ff.margin_of_error <= root_ff;
                  rsp_ff.smallest_sample <= min_ff;
                  rsp_ff.largest_sample  <= max_ff;
                  rsp_ff.saturated       <= sat_ff;
                  fill_count_ff <= '0;
                  sum_ff        <= '0;
                  min_ff        <= 32'sh7FFF_FFFF;
                  max_ff        <= 32'sh8000_0000;
                  overflow_ff   <= 1'b0;
                  state_ff      <= S_COLLECT;
               end
            end
            default: begin
               state_ff <= S_COLLECT;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The fill count never runs past the store.
   `SMSE_ASSERT(a_fill_bound, clock, reset, fill_count_ff <= FW'(MAX_SAMPLES))
   // The second pass never reads beyond the entries of this set.
   `SMSE_NEVER(a_pass_bound, clock, reset, idx_ff > fill_count_ff && state_ff == S_PASS_RD)
   // The last item of a set closes the input until the result is built.
   `SMSE_ASSERT(a_last_stalls, clock, reset, take && req_data.last_sample |=> req_stall)

endmodule

`default_nettype wire

// ===== rtl/smse_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smse_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/smse_div.sv =====
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Divides a wide unsigned dividend by the sample count, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smse_div #(
   parameter int DW = 74
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [DW-1:0]               dividend,
   input  wire logic [smse_pkg::CNT_W-1:0]  divisor,
   output logic                             done,
   output logic      [DW-1:0]               quotient
);

   localparam int VW    = smse_pkg::CNT_W;
   localparam int CNT_B = $clog2(DW + 1);

   logic [DW-1:0]    quot_ff;
   logic [VW-1:0]    rem_ff;
   logic [CNT_B-1:0] count_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [VW:0]      shifted;
   logic             fits;
   logic [VW:0]      rem_in;

   // One restoring step: bring down the next dividend bit and try a subtract.
   always_comb begin
      shifted = {rem_ff, quot_ff[DW-1]};
      fits    = (shifted >= {1'b0, divisor});
      rem_in  = fits ? (shifted - {1'b0, divisor}) : shifted;
   end

   // The quotient bits shift in as the dividend bits shift out.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quot_ff  <= dividend;
            rem_ff   <= '0;
            count_ff <= CNT_B'(DW);
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            quot_ff  <= {quot_ff[DW-2:0], fits};
            rem_ff   <= rem_in[VW-1:0];
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_B'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ===== test/sample_mean_stddev_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the sample mean and standard deviation engine
// Sends sets of Q16.16 samples through the request channel. A scoreboard
// computes the statistics of each set on its own and compares them with
// every result. Both sides idle and stall at random. The sample count
// register is rewritten between phases, and the extreme values are included.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_mean_stddev_engine_tb;

   localparam int STORE_DEPTH = 1024;
   localparam int DRAIN_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 150000;

   // Keeps the statistics of the open set and the queue of expected results.
   class stats_scoreboard;
      logic [smse_pkg::CNT_W-1:0] divisor;
      logic signed [31:0] stored[$];
      bit                 dropped;
      longint             total;
      logic signed [31:0] low_mark;
      logic signed [31:0] high_mark;
      smse_pkg::rsp_type  awaited[$];
      int                 errors;

      function new();
         divisor = smse_pkg::CNT_RESET;
         errors = 0;
         clear_set();
      endfunction

      function void clear_set();
         stored.delete();
         dropped = 0;
         total = 0;
         low_mark = 32'sh7fffffff;
         high_mark = 32'sh80000000;
      endfunction

      function void set_divisor(logic [smse_pkg::CNT_W-1:0] value);
         divisor = value;
      endfunction

      function void report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endfunction

      // Integer square root, rounded down, built one bit at a time.
      function logic [31:0] floor_root(logic [63:0] value);
         logic [31:0] root;
         logic [63:0] trial;
         root = 0;
         for (int b = 31; b >= 0; b--) begin
            trial = {32'b0, root | (32'd1 << b)};
            if (trial * trial <= value)
               root = trial[31:0];
         end
         return root;
      endfunction

      // Called for every accepted sample; a last sample closes the set.
      function void note_sample(logic signed [31:0] sample, logic last);
         logic [63:0]  n;
         logic [63:0]  mag;
         logic [63:0]  q;
         logic [63:0]  dm;
         logic [127:0] sq_sum;
         logic [127:0] var_q;
         logic [127:0] moe_q;
         longint       mean;
         longint       dev;
         smse_pkg::rsp_type e;
         if (stored.size() < STORE_DEPTH) begin
            stored.push_back(sample);
            total += longint'(sample);
            if (sample < low_mark)
               low_mark = sample;
            if (sample > high_mark)
               high_mark = sample;
         end else begin
            dropped = 1;
         end
         if (!last)
            return;
         e.saturated = dropped;
         n = (divisor == 0) ? 64'd1 : {53'b0, divisor};
         mag = (total < 0) ? 64'(-total) : 64'(total);
         q = (mag + n / 2) / n;
         // The clipped mean is the one the deviations are taken from.
         if (total < 0) begin
            if (q > 64'h8000_0000) begin
               q = 64'h8000_0000;
               e.saturated = 1;
            end
            mean = -longint'(q);
         end else begin
            if (q > 64'h7fff_ffff) begin
               q = 64'h7fff_ffff;
               e.saturated = 1;
            end
            mean = longint'(q);
         end
         sq_sum = 0;
         foreach (stored[i]) begin
            dev = longint'(stored[i]) - mean;
            dm = (dev < 0) ? 64'(-dev) : 64'(dev);
            sq_sum = sq_sum + {64'b0, dm} * {64'b0, dm};
         end
         var_q = sq_sum / {64'b0, n};
         moe_q = sq_sum / {64'b0, n * n};
         if (var_q[127:64] != 0) begin
            e.std_deviation = 32'hffff_ffff;
            e.saturated = 1;
         end else begin
            e.std_deviation = floor_root(var_q[63:0]);
         end
         if (moe_q[127:64] != 0) begin
            e.margin_of_error = 32'hffff_ffff;
            e.saturated = 1;
         end else begin
            e.margin_of_error = floor_root(moe_q[63:0]);
         end
         e.mean_value = mean[31:0];
         e.smallest_sample = low_mark;
         e.largest_sample = high_mark;
         awaited.push_back(e);
         clear_set();
      endfunction

      // Compares one accepted result with the oldest expectation.
      function void check_result(smse_pkg::rsp_type got);
         smse_pkg::rsp_type e;
         if (awaited.size() == 0) begin
            report("result item arrived with none expected");
            return;
         end
         e = awaited.pop_front();
         if (got.mean_value !== e.mean_value)
            report($sformatf("mean_value %h, expected %h", got.mean_value, e.mean_value));
         if (got.std_deviation !== e.std_deviation)
            report($sformatf("std_deviation %h, expected %h",
                             got.std_deviation, e.std_deviation));
         if (got.margin_of_error !== e.margin_of_error)
            report($sformatf("margin_of_error %h, expected %h",
                             got.margin_of_error, e.margin_of_error));
         if (got.smallest_sample !== e.smallest_sample)
            report($sformatf("smallest_sample %h, expected %h",
                             got.smallest_sample, e.smallest_sample));
         if (got.largest_sample !== e.largest_sample)
            report($sformatf("largest_sample %h, expected %h",
                             got.largest_sample, e.largest_sample));
         if (got.saturated !== e.saturated)
            report($sformatf("saturated %b, expected %b", got.saturated, e.saturated));
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   smse_pkg::req_type          req_data;
   logic                       rsp_valid;
   logic                       rsp_stall;
   smse_pkg::rsp_type          rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [smse_pkg::CNT_W-1:0] csr_wdata;

   stats_scoreboard  stats;
   bit               idling_on;
   int               quiet_cycles;

   sample_mean_stddev_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock.
   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Result side: check accepted items and stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            stats.check_result(rsp_data);
         rsp_stall <= idling_on && ($urandom_range(99) < 33);
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL sample_mean_stddev_engine");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one sample item, with an occasional idle gap in front of it.
   task automatic send_sample(logic signed [31:0] sample, logic last);
      if (idling_on && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.sample_value <= sample;
      req_data.last_sample <= last;
      do @(posedge clock); while (req_stall);
      stats.note_sample(sample, last);
   endtask

   // Waits until every expected result is in and the engine has settled.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (stats.awaited.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the sample count register; the engine must be idle.
   task automatic write_count(logic [smse_pkg::CNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      stats.set_divisor(value);
   endtask

   function automatic logic signed [31:0] pick_sample();
      case ($urandom_range(9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2, 3: return $signed($urandom_range(65535, 0) - 32768);
         4, 5: return $signed($urandom_range(32'h000fffff, 0) - 32'h00080000);
         default: return $signed($urandom());
      endcase
   endfunction

   // One set of random samples; mostly short, sometimes long, rarely
   // long enough to fill the store and drop samples.
   task automatic send_random_set(inout int sent);
      int len;
      case ($urandom_range(99))
         0: len = STORE_DEPTH + $urandom_range(1, 8);
         1: len = STORE_DEPTH;
         2, 3, 4, 5: len = $urandom_range(17, 80);
         default: len = $urandom_range(1, 16);
      endcase
      for (int k = 0; k < len; k++)
         send_sample(pick_sample(), k == len - 1);
      sent += len;
   endtask

   initial begin
      logic [smse_pkg::CNT_W-1:0] settings[7];
      logic [31:0] mid_count;
      int sent;
      stats = new();
      idling_on = 1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed sets under the reset count: extremes and a small spread.
      send_sample(32'sh7fffffff, 1'b1);
      send_sample(32'sh80000000, 1'b0);
      send_sample(32'sh7fffffff, 1'b1);
      send_sample(-32'sd1, 1'b0);
      send_sample(32'sd0, 1'b0);
      send_sample(32'sd1, 1'b1);
      drain();

      // A count of one: clipped means in both directions, clipped deviation.
      write_count(11'd1);
      send_sample(32'sh7fffffff, 1'b0);
      send_sample(32'sh7fffffff, 1'b1);
      send_sample(32'sh80000000, 1'b0);
      send_sample(32'sh80000000, 1'b1);
      send_sample(32'sh80000000, 1'b0);
      send_sample(32'sh7fffffff, 1'b0);
      send_sample(32'sh7fffffff, 1'b1);
      drain();

      // A count of zero is taken as one.
      write_count(11'd0);
      send_sample(32'sh00018000, 1'b0);
      send_sample(-32'sh00008000, 1'b1);
      drain();

      // Random phases over several count settings, extremes among them.
      settings = '{11'd1024, 11'd2047, 11'd1, 11'd0, 11'd7, 11'd3, 11'd1024};
      mid_count = $urandom_range(2, 1023);
      settings[4] = mid_count[smse_pkg::CNT_W-1:0];
      sent = 0;
      foreach (settings[p]) begin
         write_count(settings[p]);
         idling_on = (p != 2);
         while (sent < (p + 1) * 260)
            send_random_set(sent);
         drain();
      end

      if (stats.errors == 0 && stats.awaited.size() == 0) begin
         $display("PASS sample_mean_stddev_engine");
      end else begin
         if (stats.awaited.size() != 0)
            stats.report("expected result items never arrived");
         $display("FAIL sample_mean_stddev_engine");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/smse_pkg.sv
rtl/smse_ram.sv
rtl/smse_div.sv
rtl/sample_mean_stddev_engine.sv
test/sample_mean_stddev_engine_tb.sv
